### rtl/pzog_pkg.sv
// shared types, codes and constants of the polygon zone occupancy gate
package pzog_pkg;

	localparam int COORD_W          = 24;
	localparam int IDX_W            = 6;
	localparam int DIST_W           = 24;
	localparam int NEAR_W           = 24;
	localparam int VCNT_W           = 7;
	localparam int OPCODE_W         = 3;
	localparam int CFG_IDX_W        = 4;
	localparam int CFG_DATA_W       = 24;
	localparam int DEF_MAX_VERTICES = 64;
	localparam int DEF_COORD_BITS   = 24;

	localparam logic [NEAR_W-1:0] NEAR_RESET = NEAR_W'(2560);
	localparam logic [DIST_W-1:0] FAR_AWAY   = '1;

	typedef enum logic [OPCODE_W-1:0] {
		OP_LOAD  = 3'd0,
		OP_POINT = 3'd1,
		OP_EMPTY = 3'd2,
		OP_DIST  = 3'd3,
		OP_QUERY = 3'd4
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NEAR_THR = 4'd0,
		REG_VCOUNT   = 4'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [OPCODE_W-1:0]     opcode;
		logic [IDX_W-1:0]        vertex_index;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic                    last_point;
		logic [DIST_W-1:0]       distance;
	} item_t;

	typedef struct packed {
		logic point_inside;
		logic zone_free;
		logic clear_to_go;
	} result_t;

	typedef struct packed {
		logic capture;
		logic step;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic gated;
		logic walk_done;
		logic busy;
	} dp_stat_t;

endpackage

### rtl/pzog_if.sv
// valid/ready channel interfaces for command, result and configuration words
interface pzog_item_if;
	import pzog_pkg::*;
	logic  valid;
	logic  ready;
	item_t item;
	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

interface pzog_result_if;
	import pzog_pkg::*;
	logic    valid;
	logic    ready;
	result_t result;
	modport source(output valid, output result, input ready);
	modport sink(input valid, input result, output ready);
endinterface

interface pzog_cfg_if;
	import pzog_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] value;
	modport source(output valid, output index, output value, input ready);
	modport sink(input valid, input index, input value, output ready);
endinterface

### rtl/pzog_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module pzog_ram #(
	parameter int W     = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/pzog_datapath.sv
// datapath: item and config registers, vertex ram, edge crossing pipeline, zone flags
module pzog_datapath #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_BITS   = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pzog_pkg::item_t                   item,
	input  pzog_pkg::dp_cmd_t                 cmd,
	output pzog_pkg::dp_stat_t                stat,
	input  logic                              cfg_we,
	input  logic [pzog_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pzog_pkg::CFG_DATA_W-1:0]   cfg_value,
	output pzog_pkg::result_t                 result
);

	import pzog_pkg::*;

	localparam int EFF = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
	localparam int DW  = EFF + 1;
	localparam int PW  = 2 * DW;
	localparam int AW  = $clog2(MAX_VERTICES);
	localparam int CW  = $clog2(MAX_VERTICES + 2);

	// item registers
	logic [OPCODE_W-1:0]   op_q;
	logic [IDX_W-1:0]      idx_q;
	logic signed [EFF-1:0] px_q;
	logic signed [EFF-1:0] py_q;
	logic                  last_q;
	logic [DIST_W-1:0]     dist_q;

	// config and zone state
	logic [NEAR_W-1:0] thr_q;
	logic [VCNT_W-1:0] vcnt_q;
	logic [DIST_W-1:0] cur_dist_q;
	logic              zone_q;
	logic              acc_q;
	result_t           res_q;

	// walk
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] n_eff;
	logic [CW-1:0] reads_need;
	logic [AW-1:0] raddr;
	logic          we;
	logic [2*EFF-1:0] rdata;

	logic                  rv_s1;
	logic                  first_s1;
	logic signed [EFF-1:0] prev_x_q;
	logic signed [EFF-1:0] prev_y_q;
	logic signed [EFF-1:0] xi;
	logic signed [EFF-1:0] yi;
	logic signed [DW-1:0]  sxi, syi, sxj, syj, spx, spy;
	logic                  straddle;
	logic                  xcond;

	logic                  v_s2;
	logic                  cond_s2;
	logic                  pos_s2;
	logic signed [DW-1:0]  a_s2, b_s2, c_s2, dy_s2;

	logic                  v_s3;
	logic                  cond_s3;
	logic                  pos_s3;
	logic signed [PW-1:0]  lhs_s3, rhs_s3;
	logic                  left;
	logic                  odd_q;

	logic gated;
	logic hit;
	logic zone_n;
	logic acc_n;
	logic [DIST_W-1:0] dist_n;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= item.opcode;
			idx_q  <= item.vertex_index;
			px_q   <= item.coord_x[EFF-1:0];
			py_q   <= item.coord_y[EFF-1:0];
			last_q <= item.last_point;
			dist_q <= item.distance;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= NEAR_RESET;
			vcnt_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NEAR_THR: thr_q  <= cfg_value[NEAR_W-1:0];
				REG_VCOUNT:   vcnt_q <= cfg_value[VCNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign n_eff = (32'(vcnt_q) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(vcnt_q);
	assign reads_need = (n_eff == '0) ? '0 : n_eff + CW'(1);

	// first read fetches the closing vertex, then vertices in order
	assign raddr = (cnt_q == '0) ? AW'(n_eff - CW'(1)) : AW'(cnt_q - CW'(1));
	assign we = cmd.commit && (op_q == OP_LOAD) && (32'(idx_q) < MAX_VERTICES);

	pzog_ram #(
		.W     (2 * EFF),
		.DEPTH (MAX_VERTICES)
	) u_vtx_ram (
		.clk   (clk),
		.we    (we),
		.waddr (AW'(idx_q)),
		.wdata ({px_q, py_q}),
		.re    (cmd.step),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			rv_s1    <= 1'b0;
			first_s1 <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			odd_q    <= 1'b0;
		end else begin
			if (cmd.capture) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + CW'(1);
			end
			rv_s1    <= cmd.step;
			first_s1 <= (cnt_q == '0);
			v_s2     <= rv_s1 && !first_s1;
			v_s3     <= v_s2;
			if (cmd.capture) begin
				odd_q <= 1'b0;
			end else if (v_s3 && cond_s3 && left) begin
				odd_q <= ~odd_q;
			end
		end
	end

	assign xi  = rdata[2*EFF-1:EFF];
	assign yi  = rdata[EFF-1:0];
	assign sxi = {xi[EFF-1], xi};
	assign syi = {yi[EFF-1], yi};
	assign sxj = {prev_x_q[EFF-1], prev_x_q};
	assign syj = {prev_y_q[EFF-1], prev_y_q};
	assign spx = {px_q[EFF-1], px_q};
	assign spy = {py_q[EFF-1], py_q};

	assign straddle = ((yi < py_q) && (prev_y_q >= py_q)) || ((prev_y_q < py_q) && (yi >= py_q));
	assign xcond    = (xi <= px_q) || (prev_x_q <= px_q);

	always_ff @(posedge clk) begin
		if (rv_s1) begin
			prev_x_q <= xi;
			prev_y_q <= yi;
		end
		cond_s2 <= straddle && xcond;
		pos_s2  <= prev_y_q > yi;
		a_s2    <= spy - syi;
		b_s2    <= sxj - sxi;
		c_s2    <= spx - sxi;
		dy_s2   <= syj - syi;
		cond_s3 <= cond_s2;
		pos_s3  <= pos_s2;
		lhs_s3  <= a_s2 * b_s2;
		rhs_s3  <= c_s2 * dy_s2;
	end

	assign left = pos_s3 ? (lhs_s3 < rhs_s3) : (lhs_s3 > rhs_s3);

	assign gated = cur_dist_q > thr_q;

	always_comb begin
		hit    = 1'b0;
		zone_n = zone_q;
		acc_n  = acc_q;
		dist_n = cur_dist_q;
		case (op_q)
			OP_LOAD: ;
			OP_POINT: begin
				if (!gated) begin
					hit = odd_q;
					if (odd_q) begin
						acc_n = 1'b1;
					end
					if (last_q) begin
						zone_n = ~acc_n;
						acc_n  = 1'b0;
					end
				end
			end
			OP_EMPTY: begin
				if (!gated) begin
					zone_n = ~acc_q;
					acc_n  = 1'b0;
				end
			end
			OP_DIST: dist_n = dist_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_dist_q <= FAR_AWAY;
			zone_q     <= 1'b0;
			acc_q      <= 1'b0;
		end else if (cmd.commit) begin
			cur_dist_q <= dist_n;
			zone_q     <= zone_n;
			acc_q      <= acc_n;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_q.point_inside <= hit;
			res_q.zone_free    <= zone_n;
			res_q.clear_to_go  <= (dist_n < thr_q) && zone_n;
		end
	end

	assign result         = res_q;
	assign stat.gated     = gated;
	assign stat.walk_done = (cnt_q == reads_need);
	assign stat.busy      = rv_s1 || v_s2 || v_s3;

endmodule

### rtl/pzog_ctrl.sv
// controller: capture, edge walk and drain (ungated points only), commit for each word
module pzog_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_ready,
	input  logic [pzog_pkg::OPCODE_W-1:0]   opcode,
	output pzog_pkg::dp_cmd_t               dcmd,
	input  pzog_pkg::dp_stat_t              stat,
	output logic                            res_valid,
	input  logic                            res_ready
);

	import pzog_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_WALK  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   res_valid_q;
	logic   accept;
	logic   out_free;

	assign cmd_ready = (state_q == S_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign out_free  = !res_valid_q || res_ready;

	always_comb begin
		state_d = state_q;
		dcmd    = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					dcmd.capture = 1'b1;
					state_d = ((opcode == OP_POINT) && !stat.gated) ? S_WALK : S_DONE;
				end
			end
			S_WALK: begin
				if (stat.walk_done) begin
					state_d = S_DRAIN;
				end else begin
					dcmd.step = 1'b1;
				end
			end
			S_DRAIN: begin
				if (!stat.busy) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					dcmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dcmd.commit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;

`ifndef SYNTHESIS
	a_no_read_past_end: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.step |-> !stat.walk_done)
		else $error("vertex read issued after walk finished");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.commit |-> !(res_valid_q && !res_ready))
		else $error("result word overwritten before taken");

	a_pipe_empty_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !stat.busy)
		else $error("edge pipeline still busy when a new word is accepted");

	a_commit_once: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.commit |=> !dcmd.commit)
		else $error("two commits without an accepted word between");
`endif

endmodule

### rtl/polygon_zone_occupancy_gate_top.sv
// top level of the polygon zone occupancy gate
// Each command word is handled one at a time. A cloud point that passes the
// distance gate walks every polygon edge, one vertex read per cycle from the
// single read port of the vertex ram, and then drains a three-stage crossing
// pipeline. Vertex loads, distance updates, empty clouds, status queries and
// gated points skip the walk. A new word is accepted while the previous result
// word waits on the output; the vertex ram has no reset and a vertex that was
// never loaded reads as whatever it holds.
module polygon_zone_occupancy_gate_top #(
	parameter int MAX_VERTICES = pzog_pkg::DEF_MAX_VERTICES,
	parameter int COORD_BITS   = pzog_pkg::DEF_COORD_BITS
) (
	input logic           clk,
	input logic           arst_n,
	pzog_item_if.sink     cmd,
	pzog_result_if.source res,
	pzog_cfg_if.sink      cfg
);

	import pzog_pkg::*;

	dp_cmd_t  dcmd;
	dp_stat_t stat;
	result_t  result;
	logic     res_valid;
	logic     cmd_ready;

	assign cfg.ready = 1'b1;

	pzog_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd_ready),
		.opcode    (cmd.item.opcode),
		.dcmd      (dcmd),
		.stat      (stat),
		.res_valid (res_valid),
		.res_ready (res.ready)
	);

	pzog_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_BITS   (COORD_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (cmd.item),
		.cmd       (dcmd),
		.stat      (stat),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_value (cfg.value),
		.result    (result)
	);

	assign cmd.ready  = cmd_ready;
	assign res.valid  = res_valid;
	assign res.result = result;

endmodule
